// ----- rtl/core/binary_to_decimal_ascii_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII core
// Concurrent checks clocked on clk, with or without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define B2DA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define B2DA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B2DA_ASSERT(lbl, prop, msg)
`define B2DA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants of the binary to decimal ASCII core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(VALUE_W);

  typedef logic [3:0]        digit_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam char_t ASCII_ZERO = char_t'(48);
  localparam cnt_t  CONV_LAST  = cnt_t'(VALUE_W - 1);
  localparam cnt_t  EMIT_LAST  = cnt_t'(NUM_DIGITS - 1);

  // per-cycle command to every cell of the digit chain
  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ----- rtl/core/b2da_cell.sv -----
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the double-dabble chain; also shifts digits up to emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_cell (
  input  logic                clk,
  input  b2da_pkg::cell_ctl_t ctl,
  input  logic                bit_in,
  input  b2da_pkg::digit_t    digit_in,
  output logic                bit_out,
  output b2da_pkg::digit_t    digit_q
);

  b2da_pkg::digit_t digit_r;
  b2da_pkg::digit_t digit_nxt;
  b2da_pkg::digit_t adj;

  // add three before the shift whenever the digit would overflow past nine
  always_comb begin
    adj = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
    bit_out = adj[3];
    digit_nxt = digit_r;
    if (ctl.load) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctl.emit) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_q = digit_r;

endmodule

// ----- rtl/core/binary_to_decimal_ascii_core.sv -----
// Flow: a request is taken only while idle (busy low); each conversion shifts all 32 bits
// through the ten-cell digit chain, then shifts the digits out of the top cell.
// Results cannot be stalled; leading zeros take their emit cycle without a strobe.
// Reset: synchronous, active low; returns to idle and drops the result strobe.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts a 32-bit unsigned value to ASCII decimal digits, MSB digit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_core_defines.svh"

module binary_to_decimal_ascii_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [b2da_pkg::VALUE_W-1:0]           in_value,
  output logic                                   out_strobe,
  output logic [b2da_pkg::CHAR_W-1:0]            out_digit_char,
  output logic                                   out_last_digit
);

  localparam int ND = b2da_pkg::NUM_DIGITS;

  b2da_pkg::state_t              state_r, state_nxt;
  b2da_pkg::cnt_t                cnt_r, cnt_nxt;
  logic [b2da_pkg::VALUE_W-1:0]  shreg_r, shreg_nxt;
  logic                          started_r, started_nxt;
  logic                          strobe_r, strobe_nxt;
  logic                          last_r, last_nxt;
  b2da_pkg::char_t               char_r, char_nxt;

  b2da_pkg::cell_ctl_t           ctl;
  logic                          accept;
  logic                          emit_last;
  logic                          show;
  b2da_pkg::digit_t              top_digit;
  logic [ND:0]                   carry_w;
  b2da_pkg::digit_t              digit_w [ND];
  b2da_pkg::digit_t              nbr_w   [ND];

  assign busy   = (state_r != b2da_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign ctl.load  = accept;
  assign ctl.shift = (state_r == b2da_pkg::ST_CONV);
  assign ctl.emit  = (state_r == b2da_pkg::ST_EMIT);

  assign carry_w[0] = shreg_r[b2da_pkg::VALUE_W-1];

  genvar gi;
  generate
    for (gi = 0; gi < ND; gi++) begin : g_cell
      if (gi == 0) begin : g_bottom
        assign nbr_w[gi] = '0;
      end else begin : g_upper
        assign nbr_w[gi] = digit_w[gi-1];
      end
      b2da_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .bit_in   (carry_w[gi]),
        .digit_in (nbr_w[gi]),
        .bit_out  (carry_w[gi+1]),
        .digit_q  (digit_w[gi])
      );
    end
  endgenerate

  assign top_digit = digit_w[ND-1];
  assign emit_last = (cnt_r == b2da_pkg::EMIT_LAST);
  // suppress leading zeros, but always show the units digit
  assign show      = started_r || (top_digit != 4'd0) || emit_last;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    shreg_nxt   = shreg_r;
    started_nxt = started_r;
    strobe_nxt  = 1'b0;
    last_nxt    = 1'b0;
    char_nxt    = char_r;
    case (state_r)
      b2da_pkg::ST_IDLE: begin
        if (accept) begin
          shreg_nxt   = in_value;
          cnt_nxt     = '0;
          started_nxt = 1'b0;
          state_nxt   = b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        shreg_nxt = {shreg_r[b2da_pkg::VALUE_W-2:0], 1'b0};
        if (cnt_r == b2da_pkg::CONV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = b2da_pkg::ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      b2da_pkg::ST_EMIT: begin
        strobe_nxt = show;
        last_nxt   = emit_last;
        char_nxt   = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
        if (show) begin
          started_nxt = 1'b1;
        end
        if (emit_last) begin
          cnt_nxt   = '0;
          state_nxt = b2da_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = b2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= b2da_pkg::ST_IDLE;
      cnt_r     <= '0;
      started_r <= 1'b0;
      strobe_r  <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
      strobe_r  <= strobe_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    char_r  <= char_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_last_digit = last_r;
  assign out_digit_char = char_r;

  `B2DA_ASSERT(a_last_ends_run, out_strobe && out_last_digit |=> !out_strobe, "result after last digit")
  `B2DA_ASSERT(a_last_has_strobe, out_last_digit |-> out_strobe, "last digit without strobe")
  `B2DA_ASSERT(a_accept_to_conv, start && !busy |=> state_r == b2da_pkg::ST_CONV, "request not taken")
  `B2DA_ASSERT(a_no_overflow, ctl.shift |-> !carry_w[ND], "carry out of top digit cell")
  `B2DA_ASSERT(a_top_digit_bcd, ctl.emit |-> top_digit <= 4'd9, "top digit cell holds non-BCD")
  `B2DA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe && !busy, "reset did not clear control")

endmodule
